// File: rtl/pli_pkg.sv
// Shared types, constants and the control store of the piecewise linear interpolator.
package pli_pkg;

    // Field widths fixed by the interface.
    localparam int DATA_W         = 32;
    localparam int COUNT_W        = 9;
    localparam int INDEX_W        = 8;
    localparam int STATUS_W       = 2;
    localparam int PROD_W         = 2 * DATA_W;
    localparam int DIV_CNT_W      = 5;
    localparam int DEF_MAX_POINTS = 256;

    // Operation codes carried on the operation port.
    localparam logic OP_LOAD   = 1'b0;
    localparam logic OP_LOOKUP = 1'b1;

    // Result status codes.
    typedef enum logic [STATUS_W-1:0] {
        STATUS_OK    = 2'd0,
        STATUS_NOSEG = 2'd1,
        STATUS_EMPTY = 2'd2
    } status_t;

    // Sequencer step addresses.
    typedef enum logic [3:0] {
        ST_IDLE,
        ST_RD_FIRST,
        ST_CHK_FIRST,
        ST_CHK_LAST,
        ST_SCAN,
        ST_SUB,
        ST_MUL,
        ST_DIV_INIT,
        ST_DIV,
        ST_FINISH,
        ST_EMIT_CLAMP,
        ST_EMIT_NOSEG,
        ST_EMIT_EMPTY
    } step_t;

    // Jump conditions; the encoding indexes the condition flag vector.
    typedef enum logic [2:0] {
        COND_NEVER,
        COND_START,
        COND_N_ZERO,
        COND_Q_LE,
        COND_Q_GE,
        COND_IN_SEG,
        COND_SCAN_END,
        COND_DIV_DONE
    } cond_t;

    // Breakpoint memory read address select.
    typedef enum logic [1:0] {
        RD_ZERO,
        RD_LAST,
        RD_NEXT,
        RD_AHEAD
    } rd_sel_t;

    // Datapath operation of one step.
    typedef enum logic [2:0] {
        DP_NONE,
        DP_SUB,
        DP_MUL,
        DP_DIV_INIT,
        DP_DIV_STEP
    } dp_op_t;

    // Result word source.
    typedef enum logic [2:0] {
        OUT_NONE,
        OUT_CLAMP,
        OUT_CALC,
        OUT_NOSEG,
        OUT_EMPTY
    } out_sel_t;

    // One control word.
    typedef struct packed {
        rd_sel_t  rd_sel;
        logic     ld_a;
        logic     ld_b;
        logic     adv;
        dp_op_t   dp_op;
        out_sel_t out_sel;
        cond_t    cond1;
        step_t    target1;
        cond_t    cond2;
        step_t    target2;
        step_t    next;
    } ucode_t;

    // Divider controls.
    typedef struct packed {
        logic init;
        logic step;
    } div_ctl_t;

    // Control store. The first taken jump wins; otherwise the step goes to next.
    // The adv action applies only when the step falls through.
    function automatic ucode_t ucode_rom(input step_t step);
        ucode_t w;
        w = '{rd_sel: RD_ZERO, ld_a: 1'b0, ld_b: 1'b0, adv: 1'b0, dp_op: DP_NONE,
              out_sel: OUT_NONE, cond1: COND_NEVER, target1: ST_IDLE,
              cond2: COND_NEVER, target2: ST_IDLE, next: ST_IDLE};
        unique case (step)
            ST_IDLE:
            begin
                w.cond1   = COND_START;
                w.target1 = ST_RD_FIRST;
                w.next    = ST_IDLE;
            end
            ST_RD_FIRST:
            begin
                w.rd_sel  = RD_ZERO;
                w.cond1   = COND_N_ZERO;
                w.target1 = ST_EMIT_EMPTY;
                w.next    = ST_CHK_FIRST;
            end
            ST_CHK_FIRST:
            begin
                w.rd_sel  = RD_LAST;
                w.ld_a    = 1'b1;
                w.ld_b    = 1'b1;
                w.cond1   = COND_Q_LE;
                w.target1 = ST_EMIT_CLAMP;
                w.next    = ST_CHK_LAST;
            end
            ST_CHK_LAST:
            begin
                w.rd_sel  = RD_NEXT;
                w.ld_b    = 1'b1;
                w.cond1   = COND_Q_GE;
                w.target1 = ST_EMIT_CLAMP;
                w.next    = ST_SCAN;
            end
            ST_SCAN:
            begin
                w.rd_sel  = RD_AHEAD;
                w.ld_b    = 1'b1;
                w.adv     = 1'b1;
                w.cond1   = COND_IN_SEG;
                w.target1 = ST_SUB;
                w.cond2   = COND_SCAN_END;
                w.target2 = ST_EMIT_NOSEG;
                w.next    = ST_SCAN;
            end
            ST_SUB:
            begin
                w.dp_op = DP_SUB;
                w.next  = ST_MUL;
            end
            ST_MUL:
            begin
                w.dp_op = DP_MUL;
                w.next  = ST_DIV_INIT;
            end
            ST_DIV_INIT:
            begin
                w.dp_op = DP_DIV_INIT;
                w.next  = ST_DIV;
            end
            ST_DIV:
            begin
                w.dp_op   = DP_DIV_STEP;
                w.cond1   = COND_DIV_DONE;
                w.target1 = ST_FINISH;
                w.next    = ST_DIV;
            end
            ST_FINISH:
            begin
                w.out_sel = OUT_CALC;
                w.next    = ST_IDLE;
            end
            ST_EMIT_CLAMP:
            begin
                w.out_sel = OUT_CLAMP;
                w.next    = ST_IDLE;
            end
            ST_EMIT_NOSEG:
            begin
                w.out_sel = OUT_NOSEG;
                w.next    = ST_IDLE;
            end
            ST_EMIT_EMPTY:
            begin
                w.out_sel = OUT_EMPTY;
                w.next    = ST_IDLE;
            end
            default:
            begin
                w.next = ST_IDLE;
            end
        endcase
        return w;
    endfunction

endpackage

// File: rtl/pli_div.sv
// Restoring divider, one quotient bit per step, for a quotient known to fit in 32 bits.
module pli_div (
    input  logic                             clk,
    input  logic                             rst_n,
    input  pli_pkg::div_ctl_t                ctl,
    input  logic [pli_pkg::PROD_W-1:0]       dividend,
    input  logic [pli_pkg::DATA_W-1:0]       divisor,
    output logic [pli_pkg::DATA_W-1:0]       quotient,
    output logic                             last
);

    logic [pli_pkg::DATA_W:0]        rem_reg;
    logic [pli_pkg::DATA_W-1:0]      quo_reg;
    logic [pli_pkg::DIV_CNT_W-1:0]   cnt_reg;
    logic [pli_pkg::DATA_W:0]        shifted;
    logic [pli_pkg::DATA_W:0]        diff;
    logic                            fits;

    // Trial subtraction of one step; the remainder stays below the divisor.
    always_comb
    begin
        shifted = {rem_reg[pli_pkg::DATA_W-1:0], quo_reg[pli_pkg::DATA_W-1]};
        diff    = shifted - {1'b0, divisor};
        fits    = shifted >= {1'b0, divisor};
    end

    // Step counter.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
        end
        else if (ctl.init)
        begin
            cnt_reg <= '0;
        end
        else if (ctl.step)
        begin
            cnt_reg <= cnt_reg + pli_pkg::DIV_CNT_W'(1);
        end
    end

    // Remainder and quotient shift registers; the high dividend half seeds the remainder.
    always_ff @(posedge clk)
    begin
        if (ctl.init)
        begin
            rem_reg <= {1'b0, dividend[pli_pkg::PROD_W-1:pli_pkg::DATA_W]};
            quo_reg <= dividend[pli_pkg::DATA_W-1:0];
        end
        else if (ctl.step)
        begin
            rem_reg <= fits ? diff : shifted;
            quo_reg <= {quo_reg[pli_pkg::DATA_W-2:0], fits};
        end
    end

    assign quotient = quo_reg;
    assign last     = (cnt_reg == {pli_pkg::DIV_CNT_W{1'b1}});

endmodule

// File: rtl/piecewise_linear_interpolator.sv
// Top level of the piecewise linear interpolator: breakpoint memory and microcoded sequencer.
//
// Usage. Items enter on start when busy is low. A load word (operation 0) writes one
// breakpoint (point_x, point_y) at point_index in the accepting cycle; busy stays low,
// so loads may follow back to back, and a slot at or above MAX_POINTS is ignored.
// A lookup word (operation 1) raises busy and returns one result: done is high for
// exactly one cycle with interpolated and status valid in that cycle. The receiver
// cannot stall, so the result must be taken when done is high.
// The number of breakpoints in use is written through cfg_wr_en / cfg_wr_data while
// no lookup is running; counts above MAX_POINTS act as MAX_POINTS.
// An empty table or a query clamped to the first or last point is answered without a
// scan. Otherwise the segment scan does one memory read per segment, and a query that
// falls in a segment then runs the 32-step divider. busy stays high throughout a
// lookup, so no new word is taken before its result is shown.
// A new word is accepted in the cycle in which done is shown.
// Reset clears the sequencer, the result strobe and the point count; breakpoint contents
// are undefined until written and need no clearing.
module piecewise_linear_interpolator #(
    parameter int MAX_POINTS = pli_pkg::DEF_MAX_POINTS
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               start,
    output logic                               busy,
    input  logic                               operation,
    input  logic [pli_pkg::INDEX_W-1:0]        point_index,
    input  logic signed [pli_pkg::DATA_W-1:0]  point_x,
    input  logic signed [pli_pkg::DATA_W-1:0]  point_y,
    input  logic signed [pli_pkg::DATA_W-1:0]  query_value,
    input  logic                               cfg_wr_en,
    input  logic [pli_pkg::COUNT_W-1:0]        cfg_wr_data,
    output logic                               done,
    output logic signed [pli_pkg::DATA_W-1:0]  interpolated,
    output logic [pli_pkg::STATUS_W-1:0]       status
);

    localparam int AW = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
    localparam int CW = $clog2(MAX_POINTS + 1);
    localparam int SW = CW + 1;
    localparam int DW = pli_pkg::DATA_W;

    // Sequencer state.
    pli_pkg::step_t   pc_reg;
    pli_pkg::step_t   pc_next;
    pli_pkg::ucode_t  uc;
    logic [7:0]       flags;
    logic             taken1;
    logic             taken2;
    logic             adv_en;

    // Configuration and per-lookup context.
    logic [pli_pkg::COUNT_W-1:0]  point_count_reg;
    logic [CW-1:0]                n_reg;
    logic [CW-1:0]                n_sat;
    logic [AW-1:0]                idx_reg;
    logic signed [DW-1:0]         q_reg;

    // Breakpoint memory, x in the upper half and y in the lower half.
    logic [2*DW-1:0]   bp_mem [MAX_POINTS];
    logic [2*DW-1:0]   rd_reg;
    logic [AW-1:0]     rd_addr;
    logic signed [DW-1:0] rd_x;

    // Segment endpoints and arithmetic registers.
    logic signed [DW-1:0]        a_x_reg;
    logic signed [DW-1:0]        a_y_reg;
    logic signed [DW-1:0]        b_x_reg;
    logic signed [DW-1:0]        b_y_reg;
    logic [DW-1:0]               off_reg;
    logic [DW-1:0]               dx_reg;
    logic [DW-1:0]               mag_reg;
    logic                        neg_reg;
    logic [pli_pkg::PROD_W-1:0]  prod_reg;
    logic signed [DW:0]          dy;
    logic [DW:0]                 dy_abs;

    // Divider connection.
    pli_pkg::div_ctl_t  div_ctl;
    logic [DW-1:0]      quotient;
    logic               div_last;

    // Result registers.
    logic                   done_reg;
    logic signed [DW-1:0]   result_reg;
    pli_pkg::status_t       status_reg;

    logic load_accept;
    logic lookup_accept;
    logic load_in_range;

    assign load_accept   = start && !busy && (operation == pli_pkg::OP_LOAD);
    assign lookup_accept = start && !busy && (operation == pli_pkg::OP_LOOKUP);
    assign load_in_range = (32'(point_index) < 32'(MAX_POINTS));
    assign n_sat = (32'(point_count_reg) > 32'(MAX_POINTS)) ? CW'(MAX_POINTS)
                                                           : CW'(point_count_reg);
    assign rd_x  = rd_reg[2*DW-1:DW];

    // Control word of the current step.
    assign uc = pli_pkg::ucode_rom(pc_reg);

    // Condition flags, indexed by condition code.
    always_comb
    begin
        flags                         = '0;
        flags[pli_pkg::COND_START]    = lookup_accept;
        flags[pli_pkg::COND_N_ZERO]   = (n_reg == '0);
        flags[pli_pkg::COND_Q_LE]     = (q_reg <= rd_x);
        flags[pli_pkg::COND_Q_GE]     = (q_reg >= rd_x);
        flags[pli_pkg::COND_IN_SEG]   = (q_reg >= a_x_reg) && (q_reg < rd_x);
        flags[pli_pkg::COND_SCAN_END] = (SW'(idx_reg) + SW'(2)) >= SW'(n_reg);
        flags[pli_pkg::COND_DIV_DONE] = div_last;
    end

    // Next step: first taken jump, else the fall-through address.
    always_comb
    begin
        taken1 = flags[uc.cond1];
        taken2 = flags[uc.cond2];
        adv_en = uc.adv && !taken1 && !taken2;
        priority if (taken1)
        begin
            pc_next = uc.target1;
        end
        else if (taken2)
        begin
            pc_next = uc.target2;
        end
        else
        begin
            pc_next = uc.next;
        end
    end

    // Step counter.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pc_reg <= pli_pkg::ST_IDLE;
        end
        else
        begin
            pc_reg <= pc_next;
        end
    end

    assign busy = (pc_reg != pli_pkg::ST_IDLE);

    // Point count register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            point_count_reg <= '0;
        end
        else if (cfg_wr_en)
        begin
            point_count_reg <= cfg_wr_data;
        end
    end

    // Read address select.
    always_comb
    begin
        unique case (uc.rd_sel)
            pli_pkg::RD_ZERO:  rd_addr = '0;
            pli_pkg::RD_LAST:  rd_addr = AW'(n_reg - CW'(1));
            pli_pkg::RD_NEXT:  rd_addr = idx_reg + AW'(1);
            pli_pkg::RD_AHEAD: rd_addr = idx_reg + AW'(2);
            default:           rd_addr = '0;
        endcase
    end

    // Breakpoint memory: one write port for loads, one registered read port.
    always_ff @(posedge clk)
    begin
        if (load_accept && load_in_range)
        begin
            bp_mem[AW'(point_index)] <= {point_x, point_y};
        end
        rd_reg <= bp_mem[rd_addr];
    end

    // Lookup context and scan index.
    always_ff @(posedge clk)
    begin
        if (lookup_accept)
        begin
            q_reg   <= query_value;
            n_reg   <= n_sat;
            idx_reg <= '0;
        end
        else if (adv_en)
        begin
            idx_reg <= idx_reg + AW'(1);
        end
    end

    // Segment endpoint registers.
    always_ff @(posedge clk)
    begin
        if (uc.ld_a || adv_en)
        begin
            a_x_reg <= rd_reg[2*DW-1:DW];
            a_y_reg <= rd_reg[DW-1:0];
        end
        if (uc.ld_b)
        begin
            b_x_reg <= rd_reg[2*DW-1:DW];
            b_y_reg <= rd_reg[DW-1:0];
        end
    end

    // Slope terms: offset into the segment, segment width and rise magnitude.
    always_comb
    begin
        dy     = {b_y_reg[DW-1], b_y_reg} - {a_y_reg[DW-1], a_y_reg};
        dy_abs = dy[DW] ? (~dy + (DW+1)'(1)) : dy;
    end

    always_ff @(posedge clk)
    begin
        if (uc.dp_op == pli_pkg::DP_SUB)
        begin
            off_reg <= q_reg - a_x_reg;
            dx_reg  <= b_x_reg - a_x_reg;
            mag_reg <= dy_abs[DW-1:0];
            neg_reg <= dy[DW];
        end
        if (uc.dp_op == pli_pkg::DP_MUL)
        begin
            prod_reg <= pli_pkg::PROD_W'(off_reg) * pli_pkg::PROD_W'(mag_reg);
        end
    end

    assign div_ctl.init = (uc.dp_op == pli_pkg::DP_DIV_INIT);
    assign div_ctl.step = (uc.dp_op == pli_pkg::DP_DIV_STEP);

    pli_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .ctl      (div_ctl),
        .dividend (prod_reg),
        .divisor  (dx_reg),
        .quotient (quotient),
        .last     (div_last)
    );

    // Result strobe.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= (uc.out_sel != pli_pkg::OUT_NONE);
        end
    end

    // Result word.
    always_ff @(posedge clk)
    begin
        unique case (uc.out_sel)
            pli_pkg::OUT_CLAMP:
            begin
                result_reg <= b_y_reg;
                status_reg <= pli_pkg::STATUS_OK;
            end
            pli_pkg::OUT_CALC:
            begin
                result_reg <= neg_reg ? (a_y_reg - quotient) : (a_y_reg + quotient);
                status_reg <= pli_pkg::STATUS_OK;
            end
            pli_pkg::OUT_NOSEG:
            begin
                result_reg <= '0;
                status_reg <= pli_pkg::STATUS_NOSEG;
            end
            pli_pkg::OUT_EMPTY:
            begin
                result_reg <= '0;
                status_reg <= pli_pkg::STATUS_EMPTY;
            end
            default:
            begin
                result_reg <= result_reg;
                status_reg <= status_reg;
            end
        endcase
    end

    assign done         = done_reg;
    assign interpolated = result_reg;
    assign status       = status_reg;

endmodule

// File: rtl/pli_chk.sv
// Port-level checker for the piecewise linear interpolator and its bind.
module pli_chk (
    input logic                               clk,
    input logic                               rst_n,
    input logic                               start,
    input logic                               busy,
    input logic                               operation,
    input logic [pli_pkg::INDEX_W-1:0]        point_index,
    input logic signed [pli_pkg::DATA_W-1:0]  point_x,
    input logic signed [pli_pkg::DATA_W-1:0]  point_y,
    input logic signed [pli_pkg::DATA_W-1:0]  query_value,
    input logic                               cfg_wr_en,
    input logic [pli_pkg::COUNT_W-1:0]        cfg_wr_data,
    input logic                               done,
    input logic signed [pli_pkg::DATA_W-1:0]  interpolated,
    input logic [pli_pkg::STATUS_W-1:0]       status
);

    // A result is only shown once the sequencer has returned to idle.
    assert property (@(posedge clk) disable iff (!rst_n) done |-> !busy)
        else $error("result shown while busy");

    // An accepted lookup always starts the sequencer.
    assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && operation == pli_pkg::OP_LOOKUP) |=> busy)
        else $error("lookup accepted but busy not raised");

    // A breakpoint load completes in its own cycle and never yields a result.
    assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && operation == pli_pkg::OP_LOAD) |=> (!busy && !done))
        else $error("load started work or produced a result");

    // Error results carry a zero value and a defined status code.
    assert property (@(posedge clk) disable iff (!rst_n)
        (done && status != pli_pkg::STATUS_OK) |->
        ((status == pli_pkg::STATUS_NOSEG || status == pli_pkg::STATUS_EMPTY)
         && interpolated == '0))
        else $error("bad error result");

    // The result strobe is a single-cycle pulse.
    assert property (@(posedge clk) disable iff (!rst_n) done |=> !done)
        else $error("result strobe longer than one cycle");

endmodule

bind piecewise_linear_interpolator pli_chk u_pli_chk (.*);

// File: tb/testbench.sv
// Self-checking testbench for the piecewise linear interpolator.
module testbench;

    timeunit 1ns;
    timeprecision 1ps;

    import pli_pkg::*;

    localparam int          TABLE_DEPTH = DEF_MAX_POINTS;
    localparam int unsigned CYCLE_LIMIT = 1_000_000;
    localparam int          SETTLE_CYCLES = 8;
    localparam int          PRINT_LIMIT = 20;
    localparam longint      Q_MIN = -64'sd2147483648;
    localparam longint      Q_MAX = 64'sd2147483647;

    // One word as presented on the input ports.
    typedef struct {
        logic                     op;
        logic [INDEX_W-1:0]       index;
        logic signed [DATA_W-1:0] px;
        logic signed [DATA_W-1:0] py;
        logic signed [DATA_W-1:0] query;
    } word_t;

    // One lookup answer; on_segment only feeds the coverage summary.
    typedef struct {
        logic signed [DATA_W-1:0] value;
        status_t                  status;
        bit                       on_segment;
    } lut_result_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic start = 1'b0;
    logic busy;
    logic operation = OP_LOAD;
    logic [INDEX_W-1:0] point_index = '0;
    logic signed [DATA_W-1:0] point_x = '0;
    logic signed [DATA_W-1:0] point_y = '0;
    logic signed [DATA_W-1:0] query_value = '0;
    logic cfg_wr_en = 1'b0;
    logic [COUNT_W-1:0] cfg_wr_data = '0;
    logic done;
    logic signed [DATA_W-1:0] interpolated;
    logic [STATUS_W-1:0] status;

    // Predictor state: breakpoint table and point count as the block should hold them.
    logic signed [DATA_W-1:0] tbl_x [TABLE_DEPTH];
    logic signed [DATA_W-1:0] tbl_y [TABLE_DEPTH];
    int model_count = 0;

    // Stimulus-side view of the table, used to aim queries and avoid unwritten entries.
    longint gen_x [TABLE_DEPTH];
    longint gen_y [TABLE_DEPTH];
    bit     gen_written [TABLE_DEPTH];

    word_t       pending_words [$];
    lut_result_t expected_lookups [$];
    word_t       cur_word;

    int  words_queued = 0;
    int  words_accepted = 0;
    int  idle_left = 0;
    bit  burst_mode = 1'b0;
    int  mismatch_count = 0;
    int  results_seen = 0;
    int  cycle_count = 0;
    int  n_loads = 0;
    int  n_interp = 0;
    int  n_clamped = 0;
    int  n_empty = 0;
    int  n_noseg = 0;
    int  n_count_writes = 0;

    piecewise_linear_interpolator u_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .operation    (operation),
        .point_index  (point_index),
        .point_x      (point_x),
        .point_y      (point_y),
        .query_value  (query_value),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_wr_data  (cfg_wr_data),
        .done         (done),
        .interpolated (interpolated),
        .status       (status)
    );

    initial
    begin
        forever #1 clk = ~clk;
    end

    // Interpolate over the predicted table at query q.
    function automatic lut_result_t interpolate_at(input logic signed [DATA_W-1:0] q);
        lut_result_t r;
        int          n;
        int          i;
        bit          found;
        longint      q_l;
        longint      x0;
        longint      x1;
        longint      y0;
        longint      dy;
        longint      acc;
        logic [63:0] off;
        logic [63:0] dx;
        logic [63:0] mag;
        logic [63:0] quo;
        r.value = '0;
        r.status = STATUS_NOSEG;
        r.on_segment = 1'b0;
        n = (model_count > TABLE_DEPTH) ? TABLE_DEPTH : model_count;
        q_l = q;
        if (n == 0)
        begin
            r.status = STATUS_EMPTY;
        end
        else if (q <= tbl_x[0])
        begin
            r.value = tbl_y[0];
            r.status = STATUS_OK;
        end
        else if (q >= tbl_x[n-1])
        begin
            r.value = tbl_y[n-1];
            r.status = STATUS_OK;
        end
        else
        begin
            found = 1'b0;
            for (i = 0; i + 1 < n && !found; i++)
            begin
                x0 = tbl_x[i];
                x1 = tbl_x[i+1];
                if (q_l >= x0 && q_l < x1)
                begin
                    found = 1'b1;
                    y0 = tbl_y[i];
                    dy = longint'(tbl_y[i+1]) - y0;
                    off = q_l - x0;
                    dx = x1 - x0;
                    mag = (dy < 0) ? -dy : dy;
                    // The product stays below 2^64, and the quotient below 2^32.
                    quo = (off * mag) / dx;
                    acc = (dy < 0) ? y0 - longint'(quo) : y0 + longint'(quo);
                    r.value = acc[DATA_W-1:0];
                    r.status = STATUS_OK;
                    r.on_segment = 1'b1;
                end
            end
        end
        return r;
    endfunction

    // Apply one accepted word to the predictor and record what the block must answer.
    task automatic predict_word(input word_t w);
        lut_result_t r;
        if (w.op == OP_LOAD)
        begin
            if (w.index < TABLE_DEPTH)
            begin
                tbl_x[w.index] = w.px;
                tbl_y[w.index] = w.py;
            end
            n_loads++;
        end
        else
        begin
            r = interpolate_at(w.query);
            expected_lookups.push_back(r);
            if (r.status == STATUS_EMPTY)
                n_empty++;
            else if (r.status == STATUS_NOSEG)
                n_noseg++;
            else if (r.on_segment)
                n_interp++;
            else
                n_clamped++;
        end
    endtask

    task automatic report_mismatch(input string what);
        mismatch_count++;
        if (mismatch_count <= PRINT_LIMIT)
            $display("MISMATCH at cycle %0d: %s", cycle_count, what);
    endtask

    // Gap before the next word: mostly none or short, now and then long.
    function automatic int pick_idle();
        int r;
        if (burst_mode)
            return 0;
        r = $urandom_range(99, 0);
        if (r < 55)
            return 0;
        else if (r < 90)
            return $urandom_range(3, 1);
        else
            return $urandom_range(60, 4);
    endfunction

    // Driver: presents queued words and holds each until start meets a low busy.
    always @(posedge clk)
    begin
        bit fire;
        if (!rst_n)
        begin
            start <= 1'b0;
        end
        else
        begin
            fire = start && !busy;
            if (fire)
            begin
                predict_word(cur_word);
                words_accepted++;
            end
            if (fire || !start)
            begin
                if (idle_left > 0)
                begin
                    idle_left--;
                    start <= 1'b0;
                end
                else if (pending_words.size() > 0)
                begin
                    cur_word = pending_words.pop_front();
                    operation <= cur_word.op;
                    point_index <= cur_word.index;
                    point_x <= cur_word.px;
                    point_y <= cur_word.py;
                    query_value <= cur_word.query;
                    start <= 1'b1;
                    idle_left = pick_idle();
                end
                else
                begin
                    start <= 1'b0;
                end
            end
        end
    end

    // Monitor: every done strobe is checked against the oldest expected lookup.
    always @(posedge clk)
    begin
        lut_result_t e;
        if (rst_n && done)
        begin
            results_seen++;
            if (expected_lookups.size() == 0)
            begin
                report_mismatch($sformatf("result %0d arrived with no lookup pending",
                                          results_seen));
            end
            else
            begin
                e = expected_lookups.pop_front();
                if (interpolated !== e.value)
                    report_mismatch($sformatf("result %0d: interpolated %h, expected %h",
                                              results_seen, interpolated, e.value));
                if (status !== e.status)
                    report_mismatch($sformatf("result %0d: status %0d, expected %0d",
                                              results_seen, status, e.status));
            end
        end
    end

    // Watchdog on the total run length.
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("Timeout after %0d cycles", cycle_count);
            $display("Verification failed");
            $finish;
        end
    end

    task automatic queue_load(input int idx, input longint x, input longint y);
        word_t w;
        w.op = OP_LOAD;
        w.index = idx[INDEX_W-1:0];
        w.px = x[DATA_W-1:0];
        w.py = y[DATA_W-1:0];
        w.query = $urandom();
        gen_x[idx] = longint'(w.px);
        gen_y[idx] = longint'(w.py);
        gen_written[idx] = 1'b1;
        pending_words.push_back(w);
        words_queued++;
    endtask

    task automatic queue_lookup(input longint q);
        word_t w;
        w.op = OP_LOOKUP;
        w.index = $urandom();
        w.px = $urandom();
        w.py = $urandom();
        w.query = q[DATA_W-1:0];
        pending_words.push_back(w);
        words_queued++;
    endtask

    // Hold until every word is taken and every lookup answered, then let the block settle.
    task automatic wait_idle();
        while (words_accepted != words_queued || busy || start
               || expected_lookups.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // Write the point count; only called while the block is idle.
    task automatic write_point_count(input int value);
        @(posedge clk);
        cfg_wr_en <= 1'b1;
        cfg_wr_data <= value[COUNT_W-1:0];
        @(posedge clk);
        model_count = value;
        cfg_wr_en <= 1'b0;
        n_count_writes++;
    endtask

    // Load entries 0..n-1: mostly ascending x at a random pitch, sometimes scrambled.
    task automatic build_table(input int n);
        longint      span;
        longint      room;
        longint      x;
        longint      y;
        longint      pitch;
        int unsigned step;
        int          i;
        bit          scrambled;
        bit          smooth_y;
        scrambled = ($urandom_range(9, 0) == 0);
        smooth_y = $urandom_range(1, 0);
        case ($urandom_range(3, 0))
            0: pitch = $urandom_range(16, 1);
            1: pitch = 4096;
            2: pitch = 64'd1 << 20;
            default: pitch = 64'd1 << 31;
        endcase
        if (pitch * n > 64'hFFFF_FFFF)
            pitch = 64'hFFFF_FFFF / n;
        span = pitch * n;
        room = 64'hFFFF_FFFF - span;
        x = Q_MIN + (longint'($urandom()) % (room + 1));
        y = $signed($urandom());
        for (i = 0; i < n; i++)
        begin
            if (scrambled)
                x = $signed($urandom());
            else if (i > 0)
            begin
                step = ($urandom_range(15, 0) == 0) ? 0 : $urandom_range(pitch, 1);
                x = x + step;
            end
            if (smooth_y && i > 0)
                y = longint'($signed(y[DATA_W-1:0])) + $signed($urandom_range(131072, 0))
                    - 65536;
            else
                y = $signed($urandom());
            queue_load(i, x, y);
        end
    endtask

    // Pick a query aimed at the loaded table: end points, neighbors and segment interiors.
    function automatic longint pick_query(input int n);
        int     i;
        int     r;
        longint lo;
        longint hi;
        if (n == 0)
            return $signed($urandom());
        r = $urandom_range(7, 0);
        i = $urandom_range(n - 1, 0);
        case (r)
            0: return $signed($urandom());
            1: return gen_x[i];
            2: return (gen_x[i] == Q_MAX) ? Q_MAX : gen_x[i] + 1;
            3: return (gen_x[i] == Q_MIN) ? Q_MIN : gen_x[i] - 1;
            default:
            begin
                if (n < 2)
                    return $signed($urandom());
                i = $urandom_range(n - 2, 0);
                lo = gen_x[i];
                hi = gen_x[i+1];
                if (hi <= lo)
                    return lo;
                return lo + (longint'($urandom()) % (hi - lo));
            end
        endcase
    endfunction

    // Main sequence: directed words, then phases over a range of point counts.
    initial
    begin
        int     counts [12];
        int     p;
        int     k;
        int     n_eff;
        int     i;
        bit     need_reload;
        for (i = 0; i < TABLE_DEPTH; i++)
            gen_written[i] = 1'b0;

        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Empty table straight out of reset.
        queue_lookup(Q_MIN);
        queue_lookup(Q_MAX);

        // Four points spanning the whole input range, plus the top slot.
        queue_load(0, Q_MIN, Q_MAX);
        queue_load(1, -65536, 0);
        queue_load(2, 65536, Q_MIN);
        queue_load(3, Q_MAX, Q_MAX);
        queue_load(TABLE_DEPTH - 1, 32'h5555_5555, -32'sh5555_5556);
        wait_idle();

        write_point_count(4);
        queue_lookup(Q_MIN);
        queue_lookup(Q_MIN + 1);
        queue_lookup(-65536);
        queue_lookup(0);
        queue_lookup(65535);
        queue_lookup(Q_MAX - 1);
        queue_lookup(Q_MAX);
        wait_idle();

        // A single point clamps from both sides; two points clamp past the second.
        write_point_count(1);
        queue_lookup(0);
        queue_lookup(Q_MIN);
        wait_idle();
        write_point_count(2);
        queue_lookup(0);
        wait_idle();

        // Random phases, small tables mostly, and the full table with counts past capacity.
        counts = '{2, 3, $urandom_range(12, 4), 17, 256, 5, 511,
                   $urandom_range(40, 1), 0, 300, 9, $urandom_range(8, 1)};
        for (p = 0; p < 12; p++)
        begin
            n_eff = (counts[p] > TABLE_DEPTH) ? TABLE_DEPTH : counts[p];
            burst_mode = (p % 3 == 1);
            write_point_count(counts[p]);
            need_reload = (n_eff > 0 && n_eff < TABLE_DEPTH);
            for (i = 0; i < n_eff; i++)
                if (!gen_written[i])
                    need_reload = 1'b1;
            if (need_reload)
                build_table(n_eff);
            for (k = 0; k < 40; k++)
            begin
                if ($urandom_range(99, 0) < 85)
                    queue_lookup(pick_query(n_eff));
                else
                    queue_load($urandom_range(TABLE_DEPTH - 1, 0),
                               $signed($urandom()), $signed($urandom()));
            end
            // Sender holds back here until every lookup of the phase has come back.
            wait_idle();
        end

        while (expected_lookups.size() != 0)
        begin
            void'(expected_lookups.pop_front());
            report_mismatch("lookup never answered");
        end

        $display("Covered %0d breakpoint loads and %0d lookups under %0d point-count settings.",
                 n_loads, n_interp + n_clamped + n_empty + n_noseg, n_count_writes);
        $display("Lookups: %0d interpolated, %0d clamped, %0d empty table, %0d no segment.",
                 n_interp, n_clamped, n_empty, n_noseg);
        if (mismatch_count == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule

// File: files.f
rtl/pli_pkg.sv
rtl/pli_div.sv
rtl/piecewise_linear_interpolator.sv
rtl/pli_chk.sv
tb/testbench.sv
